/* rtl/tvbm_pkg.sv */
// shared types and constants for the touch virtual button mapper
// no dependencies; all other files refer to it by scoped names
`timescale 1ns / 1ps

package tvbm_pkg;

    // fixed field widths
    localparam int ID_W       = 16;
    localparam int COORD_W    = 14;
    localparam int YOFF_W     = 10;
    localparam int MASK_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // parameter defaults
    localparam int SLOT_COUNT_DEF      = 12;
    localparam int ID_BITS_DEF         = 16;
    localparam int COORD_FRAC_BITS_DEF = 4;

    // button mask bit positions
    localparam int BTN_UP     = 0;
    localparam int BTN_DOWN   = 1;
    localparam int BTN_LEFT   = 2;
    localparam int BTN_RIGHT  = 3;
    localparam int BTN_CROSS  = 4;
    localparam int BTN_CIRCLE = 5;
    localparam int BTN_START  = 6;
    localparam int BTN_SELECT = 7;

    typedef enum logic [STATUS_W-1:0] {
        EV_STORED           = 3'd0,
        EV_RELEASED         = 3'd1,
        EV_UNKNOWN_RELEASE  = 3'd2,
        EV_TABLE_FULL       = 3'd3,
        EV_DISABLED         = 3'd4
    } tvbm_status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED         = 2'd0,
        CFG_OVERLAY_VISIBLE = 2'd1,
        CFG_Y_OFFSET        = 2'd2
    } tvbm_cfg_idx_t;

    typedef enum logic [2:0] {
        IDLE,
        SCAN,
        UPDATE,
        HIT,
        DRAIN,
        FINISH
    } tvbm_state_t;

    // slot table write command
    typedef struct packed {
        logic write;
        logic free_slot;
        logic clear_all;
    } tvbm_tbl_cmd_t;

    // tag that travels with a slot through the hit tester
    typedef struct packed {
        logic hit;
        logic last;
    } tvbm_hit_tag_t;

endpackage

/* rtl/touch_virtual_button_mapper_unit.sv */
// top level of the touch virtual button mapper: sequencer, config registers, output register
// depends on tvbm_pkg, tvbm_slot_table and tvbm_hit_unit
`timescale 1ns / 1ps

// Usage
// - s_ channel carries one touch event per transaction: finger id, down/up, x and y
//   in Q10.4 pixels. m_ channel returns one result per event: button mask and status.
// - cfg_wr_en/cfg_index/cfg_wdata write enabled, overlay_visible and y_offset; write
//   only while no event is in flight. Clearing enabled empties the finger table.
// - An enabled event walks the slots once to look up the finger id, updates the table,
//   sends every slot through the shared hit tester, drains its pipeline and then loads
//   the output register. A disabled event skips the table and the hit tester and goes
//   straight to loading the output register.
// - s_ready is high only while the sequencer is idle, so one event is in work at a
//   time.
// - The result sits in an output register; the next event may be accepted while it
//   waits, and that event finishes only once the register is free.
// - A stall on m_ready holds m_valid and the result unchanged.
// - Reset (aresetn low, synchronous) empties the table, clears the config registers and m_valid.

module touch_virtual_button_mapper_unit #(
    parameter int SLOT_COUNT      = tvbm_pkg::SLOT_COUNT_DEF,
    parameter int ID_BITS         = tvbm_pkg::ID_BITS_DEF,
    parameter int COORD_FRAC_BITS = tvbm_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [tvbm_pkg::ID_W-1:0]         s_finger_id,
    input  logic                              s_is_down,
    input  logic [tvbm_pkg::COORD_W-1:0]      s_pos_x,
    input  logic [tvbm_pkg::COORD_W-1:0]      s_pos_y,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tvbm_pkg::MASK_W-1:0]       m_button_mask,
    output logic [tvbm_pkg::STATUS_W-1:0]     m_event_status,
    input  logic                              cfg_wr_en,
    input  logic [tvbm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tvbm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

    // configuration registers
    logic                                enabled_reg, visible_reg;
    logic signed [tvbm_pkg::YOFF_W-1:0]  y_offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg  <= 1'b0;
            visible_reg  <= 1'b0;
            y_offset_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tvbm_pkg::CFG_ENABLED:         enabled_reg  <= cfg_wdata[0];
                tvbm_pkg::CFG_OVERLAY_VISIBLE: visible_reg  <= cfg_wdata[0];
                tvbm_pkg::CFG_Y_OFFSET:        y_offset_reg <= cfg_wdata[tvbm_pkg::YOFF_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer state
    tvbm_pkg::tvbm_state_t  state_reg, state_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic [ID_BITS-1:0]     id_reg, id_next;
    logic                   down_reg, down_next;
    logic [tvbm_pkg::COORD_W-1:0] x_reg, x_next, y_reg, y_next;
    logic                   match_found_reg, match_found_next;
    logic [IW-1:0]          match_idx_reg, match_idx_next;
    logic                   free_found_reg, free_found_next;
    logic [IW-1:0]          free_idx_reg, free_idx_next;
    tvbm_pkg::tvbm_status_t status_reg, status_next;
    logic [tvbm_pkg::MASK_W-1:0] mask_acc_reg, mask_acc_next;
    logic                   out_valid_reg, out_valid_next;
    logic [tvbm_pkg::MASK_W-1:0] out_mask_reg, out_mask_next;
    tvbm_pkg::tvbm_status_t out_status_reg, out_status_next;

    // table and hit tester connections
    tvbm_pkg::tvbm_tbl_cmd_t  tbl_cmd;
    logic [IW-1:0]            wr_idx;
    logic                     rd_active;
    logic [ID_BITS-1:0]       rd_id;
    logic [tvbm_pkg::COORD_W-1:0] rd_x, rd_y;
    tvbm_pkg::tvbm_hit_tag_t  hit_in_tag, hit_out_tag;
    logic [tvbm_pkg::MASK_W-1:0] hit_mask;

    tvbm_slot_table #(
        .SLOT_COUNT (SLOT_COUNT),
        .ID_BITS    (ID_BITS),
        .IW         (IW)
    ) u_slot_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (tbl_cmd),
        .wr_idx    (wr_idx),
        .wr_id     (id_reg),
        .wr_x      (x_reg),
        .wr_y      (y_reg),
        .rd_idx    (idx_reg),
        .rd_active (rd_active),
        .rd_id     (rd_id),
        .rd_x      (rd_x),
        .rd_y      (rd_y)
    );

    tvbm_hit_unit #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_hit_unit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_tag   (hit_in_tag),
        .in_x     (rd_x),
        .in_y     (rd_y),
        .y_offset (y_offset_reg),
        .out_tag  (hit_out_tag),
        .out_mask (hit_mask)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tvbm_pkg::IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        id_reg          <= id_next;
        down_reg        <= down_next;
        x_reg           <= x_next;
        y_reg           <= y_next;
        match_found_reg <= match_found_next;
        match_idx_reg   <= match_idx_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        status_reg      <= status_next;
        mask_acc_reg    <= mask_acc_next;
        out_mask_reg    <= out_mask_next;
        out_status_reg  <= out_status_next;
    end

    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        id_next          = id_reg;
        down_next        = down_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        status_next      = status_reg;
        mask_acc_next    = mask_acc_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        out_mask_next    = out_mask_reg;
        out_status_next  = out_status_reg;
        tbl_cmd          = '0;
        tbl_cmd.clear_all = !enabled_reg;
        wr_idx           = match_idx_reg;
        hit_in_tag       = '0;

        if (hit_out_tag.hit) begin
            mask_acc_next = mask_acc_reg | hit_mask;
        end

        unique case (state_reg)
            tvbm_pkg::IDLE: begin
                if (s_valid) begin
                    id_next          = ID_BITS'(s_finger_id);
                    down_next        = s_is_down;
                    x_next           = s_pos_x;
                    y_next           = s_pos_y;
                    idx_next         = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    mask_acc_next    = '0;
                    if (!enabled_reg) begin
                        status_next = tvbm_pkg::EV_DISABLED;
                        state_next  = tvbm_pkg::FINISH;
                    end else begin
                        state_next  = tvbm_pkg::SCAN;
                    end
                end
            end
            tvbm_pkg::SCAN: begin
                // first active slot with the same id, first free slot
                if (rd_active && (rd_id == id_reg) && !match_found_reg) begin
                    match_found_next = 1'b1;
                    match_idx_next   = idx_reg;
                end
                if (!rd_active && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                if (idx_reg == LAST_IDX) begin
                    state_next = tvbm_pkg::UPDATE;
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            tvbm_pkg::UPDATE: begin
                if (!down_reg) begin
                    if (match_found_reg) begin
                        tbl_cmd.free_slot = 1'b1;
                        status_next       = tvbm_pkg::EV_RELEASED;
                    end else begin
                        status_next       = tvbm_pkg::EV_UNKNOWN_RELEASE;
                    end
                end else if (match_found_reg) begin
                    tbl_cmd.write = 1'b1;
                    status_next   = tvbm_pkg::EV_STORED;
                end else if (free_found_reg) begin
                    wr_idx        = free_idx_reg;
                    tbl_cmd.write = 1'b1;
                    status_next   = tvbm_pkg::EV_STORED;
                end else begin
                    status_next   = tvbm_pkg::EV_TABLE_FULL;
                end
                idx_next   = '0;
                state_next = tvbm_pkg::HIT;
            end
            tvbm_pkg::HIT: begin
                hit_in_tag.hit  = rd_active;
                hit_in_tag.last = (idx_reg == LAST_IDX);
                if (idx_reg == LAST_IDX) begin
                    state_next = tvbm_pkg::DRAIN;
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            tvbm_pkg::DRAIN: begin
                if (hit_out_tag.last) begin
                    state_next = tvbm_pkg::FINISH;
                end
            end
            tvbm_pkg::FINISH: begin
                // wait for the output register to free up
                if (!out_valid_reg || m_ready) begin
                    out_valid_next  = 1'b1;
                    out_mask_next   = visible_reg ? mask_acc_reg : '0;
                    out_status_next = status_reg;
                    state_next      = tvbm_pkg::IDLE;
                end
            end
            default: begin
                state_next = tvbm_pkg::IDLE;
            end
        endcase
    end

    assign s_ready        = (state_reg == tvbm_pkg::IDLE);
    assign m_valid        = out_valid_reg;
    assign m_button_mask  = out_mask_reg;
    assign m_event_status = out_status_reg;

endmodule

/* rtl/tvbm_slot_table.sv */
// active finger table: valid bits, finger ids and last positions per slot
// depends on tvbm_pkg
`timescale 1ns / 1ps

module tvbm_slot_table #(
    parameter int SLOT_COUNT = tvbm_pkg::SLOT_COUNT_DEF,
    parameter int ID_BITS    = tvbm_pkg::ID_BITS_DEF,
    parameter int IW         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tvbm_pkg::tvbm_tbl_cmd_t       cmd,
    input  logic [IW-1:0]                 wr_idx,
    input  logic [ID_BITS-1:0]            wr_id,
    input  logic [tvbm_pkg::COORD_W-1:0]  wr_x,
    input  logic [tvbm_pkg::COORD_W-1:0]  wr_y,
    input  logic [IW-1:0]                 rd_idx,
    output logic                          rd_active,
    output logic [ID_BITS-1:0]            rd_id,
    output logic [tvbm_pkg::COORD_W-1:0]  rd_x,
    output logic [tvbm_pkg::COORD_W-1:0]  rd_y
);

    logic [SLOT_COUNT-1:0]        active_reg;
    logic [ID_BITS-1:0]           id_reg [SLOT_COUNT];
    logic [tvbm_pkg::COORD_W-1:0] x_reg  [SLOT_COUNT];
    logic [tvbm_pkg::COORD_W-1:0] y_reg  [SLOT_COUNT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
        end else if (cmd.clear_all) begin
            active_reg <= '0;
        end else if (cmd.write) begin
            active_reg[wr_idx] <= 1'b1;
        end else if (cmd.free_slot) begin
            active_reg[wr_idx] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write && !cmd.clear_all) begin
            id_reg[wr_idx] <= wr_id;
            x_reg[wr_idx]  <= wr_x;
            y_reg[wr_idx]  <= wr_y;
        end
    end

    assign rd_active = active_reg[rd_idx];
    assign rd_id     = id_reg[rd_idx];
    assign rd_x      = x_reg[rd_idx];
    assign rd_y      = y_reg[rd_idx];

endmodule

/* rtl/tvbm_hit_unit.sv */
// shared hit tester: one slot position per cycle, three register stages
// depends on tvbm_pkg
`timescale 1ns / 1ps

module tvbm_hit_unit #(
    parameter int COORD_FRAC_BITS = tvbm_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tvbm_pkg::tvbm_hit_tag_t             in_tag,
    input  logic [tvbm_pkg::COORD_W-1:0]        in_x,
    input  logic [tvbm_pkg::COORD_W-1:0]        in_y,
    input  logic signed [tvbm_pkg::YOFF_W-1:0]  y_offset,
    output tvbm_pkg::tvbm_hit_tag_t             out_tag,
    output logic [tvbm_pkg::MASK_W-1:0]         out_mask
);

    localparam int F  = COORD_FRAC_BITS;
    localparam int S  = 1 << F;
    localparam int DW = F + 17;   // signed working width for shifted coordinates
    localparam int PW = F + 7;    // d-pad offset magnitude, up to 64 pixels
    localparam int RW = F + 6;    // round button offset magnitude, up to 33 pixels

    localparam logic signed [DW-1:0] DP_CX  = DW'(62 * S);
    localparam logic signed [DW-1:0] DP_CY  = DW'(150 * S);
    localparam logic [DW-1:0]        DP_LIM = DW'(64 * S);
    localparam logic [DW-1:0]        DP_DZ  = DW'(11 * S);
    localparam logic signed [DW-1:0] CR_CX  = DW'(444 * S);
    localparam logic signed [DW-1:0] CR_CY  = DW'(126 * S);
    localparam logic signed [DW-1:0] CI_CX  = DW'(386 * S);
    localparam logic signed [DW-1:0] CI_CY  = DW'(170 * S);
    localparam logic [DW-1:0]        RAD    = DW'(33 * S);
    localparam logic [2*RW:0]        RAD_SQ = (2*RW+1)'(1089 * S * S);
    localparam logic signed [DW-1:0] ST_X0  = DW'(398 * S);
    localparam logic signed [DW-1:0] ST_X1  = DW'(470 * S);
    localparam logic signed [DW-1:0] SE_X0  = DW'(334 * S);
    localparam logic signed [DW-1:0] SE_X1  = DW'(406 * S);
    localparam logic signed [DW-1:0] BX_Y0  = DW'(232 * S);
    localparam logic signed [DW-1:0] BX_Y1  = DW'(268 * S);

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
        logic [DW-1:0] r;
        r = v[DW-1] ? DW'(-v) : DW'(v);
        return r;
    endfunction

    // stage 1: apply y offset
    logic signed [DW-1:0] x_ext, y_ext, yoff_ext, y_adj;
    logic signed [DW-1:0] xs_reg, ys_reg;
    tvbm_pkg::tvbm_hit_tag_t tag1_reg, tag2_reg, tag3_reg;

    assign x_ext    = DW'(in_x);
    assign y_ext    = DW'(in_y);
    assign yoff_ext = DW'(y_offset);
    assign y_adj    = y_ext - (yoff_ext <<< F);

    always_ff @(posedge aclk) begin
        xs_reg <= x_ext;
        ys_reg <= y_adj;
    end

    // stage 2: offsets from each control, range checks, boxes
    logic signed [DW-1:0] dp_dx, dp_dy;
    logic [DW-1:0]        dp_ax, dp_ay, cr_ax, cr_ay, ci_ax, ci_ay;
    logic                 dp_ok, cr_near, ci_near, start_hit, select_hit;

    assign dp_dx = xs_reg - DP_CX;
    assign dp_dy = ys_reg - DP_CY;
    assign dp_ax = mag(dp_dx);
    assign dp_ay = mag(dp_dy);
    assign dp_ok = (dp_ax <= DP_LIM) && (dp_ay <= DP_LIM) &&
                   ((dp_ax > DP_DZ) || (dp_ay > DP_DZ));

    assign cr_ax   = mag(xs_reg - CR_CX);
    assign cr_ay   = mag(ys_reg - CR_CY);
    assign ci_ax   = mag(xs_reg - CI_CX);
    assign ci_ay   = mag(ys_reg - CI_CY);
    assign cr_near = (cr_ax <= RAD) && (cr_ay <= RAD);
    assign ci_near = (ci_ax <= RAD) && (ci_ay <= RAD);

    assign start_hit  = (xs_reg >= ST_X0) && (xs_reg <= ST_X1) &&
                        (ys_reg >= BX_Y0) && (ys_reg <= BX_Y1);
    assign select_hit = (xs_reg >= SE_X0) && (xs_reg <= SE_X1) &&
                        (ys_reg >= BX_Y0) && (ys_reg <= BX_Y1);

    logic          dp_ok_reg, dp_xneg_reg, dp_yneg_reg;
    logic [PW-1:0] dp_ax_reg, dp_ay_reg;
    logic          cr_near_reg, ci_near_reg, start_reg, select_reg;
    logic [RW-1:0] cr_ax_reg, cr_ay_reg, ci_ax_reg, ci_ay_reg;

    always_ff @(posedge aclk) begin
        dp_ok_reg   <= dp_ok;
        dp_xneg_reg <= dp_dx[DW-1];
        dp_yneg_reg <= dp_dy[DW-1];
        dp_ax_reg   <= dp_ax[PW-1:0];
        dp_ay_reg   <= dp_ay[PW-1:0];
        cr_near_reg <= cr_near;
        ci_near_reg <= ci_near;
        cr_ax_reg   <= cr_ax[RW-1:0];
        cr_ay_reg   <= cr_ay[RW-1:0];
        ci_ax_reg   <= ci_ax[RW-1:0];
        ci_ay_reg   <= ci_ay[RW-1:0];
        start_reg   <= start_hit;
        select_reg  <= select_hit;
    end

    // stage 3: diagonal ratio compare and squared radius
    logic [PW+4:0]   ax20, ay20, ax9, ay9;
    logic [2*RW-1:0] cr_sx, cr_sy, ci_sx, ci_sy;
    logic [2*RW:0]   cr_d2, ci_d2;
    logic [tvbm_pkg::MASK_W-1:0] mask3;

    assign ax20 = (PW+5)'(dp_ax_reg) * (PW+5)'(20);
    assign ay20 = (PW+5)'(dp_ay_reg) * (PW+5)'(20);
    assign ax9  = (PW+5)'(dp_ax_reg) * (PW+5)'(9);
    assign ay9  = (PW+5)'(dp_ay_reg) * (PW+5)'(9);

    assign cr_sx = (2*RW)'(cr_ax_reg) * (2*RW)'(cr_ax_reg);
    assign cr_sy = (2*RW)'(cr_ay_reg) * (2*RW)'(cr_ay_reg);
    assign ci_sx = (2*RW)'(ci_ax_reg) * (2*RW)'(ci_ax_reg);
    assign ci_sy = (2*RW)'(ci_ay_reg) * (2*RW)'(ci_ay_reg);
    assign cr_d2 = (2*RW+1)'(cr_sx) + (2*RW+1)'(cr_sy);
    assign ci_d2 = (2*RW+1)'(ci_sx) + (2*RW+1)'(ci_sy);

    always_comb begin
        mask3 = '0;
        if (dp_ok_reg) begin
            if (ax20 >= ay9) begin
                if (dp_xneg_reg) begin
                    mask3[tvbm_pkg::BTN_LEFT] = 1'b1;
                end else begin
                    mask3[tvbm_pkg::BTN_RIGHT] = 1'b1;
                end
            end
            if (ay20 >= ax9) begin
                if (dp_yneg_reg) begin
                    mask3[tvbm_pkg::BTN_UP] = 1'b1;
                end else begin
                    mask3[tvbm_pkg::BTN_DOWN] = 1'b1;
                end
            end
        end
        mask3[tvbm_pkg::BTN_CROSS]  = cr_near_reg && (cr_d2 <= RAD_SQ);
        mask3[tvbm_pkg::BTN_CIRCLE] = ci_near_reg && (ci_d2 <= RAD_SQ);
        mask3[tvbm_pkg::BTN_START]  = start_reg;
        mask3[tvbm_pkg::BTN_SELECT] = select_reg;
    end

    always_ff @(posedge aclk) begin
        out_mask <= mask3;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end else begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    assign out_tag = tag3_reg;

endmodule

/* rtl/tvbm_checker.sv */
// port-level checks for the touch virtual button mapper, bound to the top level
// depends on tvbm_pkg and touch_virtual_button_mapper_unit
`timescale 1ns / 1ps

module tvbm_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [tvbm_pkg::MASK_W-1:0]       m_button_mask,
    input logic [tvbm_pkg::STATUS_W-1:0]     m_event_status
);

    // one transaction in work at a time
    a_busy_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready
    ) else $error("input accepted while previous transaction still in work");

    // a fresh result never shows up right after an accept
    a_no_instant_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_valid && s_ready)
    ) else $error("result appeared one cycle after acceptance");

    a_disabled_mask_zero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_status == tvbm_pkg::EV_DISABLED) |-> (m_button_mask == '0)
    ) else $error("disabled event returned a nonzero button mask");

    a_result_held: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_button_mask) && $stable(m_event_status)
    ) else $error("result changed while stalled");

endmodule

bind touch_virtual_button_mapper_unit tvbm_checker u_tvbm_checker (.*);
